### sv/hfaf_pkg.sv
package hfaf_pkg;

    localparam int CACHE_DEPTH_DEF = 16;

    localparam int MAC_W    = 48;
    localparam int SEQ_W    = 12;
    localparam int WIN_W    = 16;
    localparam int VERD_W   = 4;
    localparam int PADDR_W  = 6;
    localparam int PDATA_W  = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [WIN_W-1:0] WINDOW_UNSET = 16'hFFFF;

    localparam logic [VERD_W-1:0] V_FORWARD   = 4'd0;
    localparam logic [VERD_W-1:0] V_INACTIVE  = 4'd1;
    localparam logic [VERD_W-1:0] V_FOREIGN   = 4'd2;
    localparam logic [VERD_W-1:0] V_RXERR     = 4'd3;
    localparam logic [VERD_W-1:0] V_NOSTA     = 4'd4;
    localparam logic [VERD_W-1:0] V_LATE      = 4'd5;
    localparam logic [VERD_W-1:0] V_DUP       = 4'd6;
    localparam logic [VERD_W-1:0] V_UNDECRYPT = 4'd7;
    localparam logic [VERD_W-1:0] V_CLEARED   = 4'd8;

    localparam logic OP_EXAMINE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_BSSID   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AP_ADDR = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OWN     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PRIVACY = 3'd4;

    typedef struct packed {
        logic             opcode;
        logic [MAC_W-1:0] frame_bssid;
        logic [MAC_W-1:0] transmitter_address;
        logic [MAC_W-1:0] receiver_address;
        logic             rx_error;
        logic             is_qos;
        logic [SEQ_W-1:0] seq_number;
        logic             still_encrypted;
        logic             station_found;
        logic             reorder_enabled;
        logic [WIN_W-1:0] window_start;
    } in_word_t;

    typedef struct packed {
        logic [VERD_W-1:0] verdict;
        logic              to_reorder;
    } out_word_t;

    typedef struct packed {
        logic [MAC_W-1:0] session_bssid;
        logic [MAC_W-1:0] bound_ap_address;
        logic [MAC_W-1:0] own_address;
        logic             group_active;
        logic             privacy_enabled;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic load_pre;
        logic scan_start;
        logic rd_en;
        logic load_fin;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

### sv/hfaf_ram.sv
module hfaf_ram
    #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
    )
    (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/hfaf_regs.sv
module hfaf_regs
    import hfaf_pkg::*;
    (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
    );

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx    = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_BSSID:   cfg_next.session_bssid    = pwdata[MAC_W-1:0];
                REG_AP_ADDR: cfg_next.bound_ap_address = pwdata[MAC_W-1:0];
                REG_OWN:     cfg_next.own_address      = pwdata[MAC_W-1:0];
                REG_ACTIVE:  cfg_next.group_active     = pwdata[0];
                REG_PRIVACY: cfg_next.privacy_enabled  = pwdata[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_BSSID:   prdata = {{(PDATA_W-MAC_W){1'b0}}, cfg_reg.session_bssid};
            REG_AP_ADDR: prdata = {{(PDATA_W-MAC_W){1'b0}}, cfg_reg.bound_ap_address};
            REG_OWN:     prdata = {{(PDATA_W-MAC_W){1'b0}}, cfg_reg.own_address};
            REG_ACTIVE:  prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.group_active};
            REG_PRIVACY: prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.privacy_enabled};
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### sv/hfaf_dpath.sv
module hfaf_dpath
    import hfaf_pkg::*;
    #(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
    )
    (
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  frame,
    input  cfg_t      cfg,
    input  cmd_t      cmd,
    output sts_t      sts,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result
    );

    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_DEPTH - 1);

    in_word_t         word_reg;
    logic [CACHE_DEPTH-1:0] valid_reg;
    logic [CACHE_DEPTH-1:0] valid_next;
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    wp_next;
    logic [AW-1:0]    cnt_reg;
    logic [AW-1:0]    cnt_next;
    logic             cmp_en_reg;
    logic             vld_q_reg;
    logic             hit_reg;
    logic             hit_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    out_word_t        result_reg;
    out_word_t        result_next;

    logic [SEQ_W-1:0] rd_data;
    logic [SEQ_W-1:0] entry;
    logic             ram_we;
    logic [SEQ_W-1:0] late_diff;
    logic             late;
    logic             foreign;
    logic             need_scan;
    out_word_t        pre_word;
    out_word_t        fin_word;

    hfaf_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (CACHE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (word_reg.seq_number),
        .re    (cmd.rd_en),
        .raddr (cnt_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            word_reg <= frame;
        end
        result_reg <= result_next;
    end

    assign late_diff = word_reg.seq_number - word_reg.window_start[SEQ_W-1:0];
    assign late      = word_reg.reorder_enabled &&
                       (word_reg.window_start != WINDOW_UNSET) && late_diff[SEQ_W-1];
    assign foreign   = (word_reg.frame_bssid != cfg.session_bssid) ||
                       (word_reg.transmitter_address != cfg.bound_ap_address) ||
                       (!word_reg.receiver_address[40] &&
                        (word_reg.receiver_address != cfg.own_address));

    always_comb
    begin
        need_scan = 1'b0;
        pre_word  = '{verdict: V_FORWARD, to_reorder: 1'b0};
        if (word_reg.opcode == OP_CLEAR)
        begin
            pre_word.verdict = V_CLEARED;
        end
        else if (!cfg.group_active)
        begin
            pre_word.verdict = V_INACTIVE;
        end
        else if (foreign)
        begin
            pre_word.verdict = V_FOREIGN;
        end
        else if (word_reg.rx_error)
        begin
            pre_word.verdict = V_RXERR;
        end
        else if (!word_reg.station_found)
        begin
            pre_word.verdict = V_NOSTA;
        end
        else if (word_reg.is_qos)
        begin
            if (late)
            begin
                pre_word.verdict = V_LATE;
            end
            else if (word_reg.still_encrypted && cfg.privacy_enabled)
            begin
                pre_word.verdict = V_UNDECRYPT;
            end
            else
            begin
                pre_word.to_reorder = 1'b1;
            end
        end
        else
        begin
            need_scan = 1'b1;
        end
    end

    // stored entries never written read as zero
    assign entry = vld_q_reg ? rd_data : '0;

    always_comb
    begin
        fin_word.to_reorder = 1'b0;
        if (hit_reg)
        begin
            fin_word.verdict = V_DUP;
        end
        else if (word_reg.still_encrypted)
        begin
            fin_word.verdict = V_UNDECRYPT;
        end
        else
        begin
            fin_word.verdict = V_FORWARD;
        end
    end

    assign ram_we = cmd.load_fin && !hit_reg;

    always_comb
    begin
        valid_next        = valid_reg;
        wp_next           = wp_reg;
        cnt_next          = cnt_reg;
        hit_next          = hit_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (cmd.scan_start)
        begin
            cnt_next = '0;
            hit_next = 1'b0;
        end
        if (cmd.rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmp_en_reg && (entry == word_reg.seq_number))
        begin
            hit_next = 1'b1;
        end
        if (cmd.load_pre)
        begin
            result_next       = pre_word;
            result_valid_next = 1'b1;
            if (word_reg.opcode == OP_CLEAR)
            begin
                valid_next = '0;
                wp_next    = '0;
            end
        end
        if (cmd.load_fin)
        begin
            result_next       = fin_word;
            result_valid_next = 1'b1;
            if (ram_we)
            begin
                valid_next[wp_reg] = 1'b1;
                wp_next = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            wp_reg           <= '0;
            cnt_reg          <= '0;
            cmp_en_reg       <= 1'b0;
            vld_q_reg        <= 1'b0;
            hit_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg        <= valid_next;
            wp_reg           <= wp_next;
            cnt_reg          <= cnt_next;
            cmp_en_reg       <= cmd.rd_en;
            vld_q_reg        <= valid_reg[cnt_reg];
            hit_reg          <= hit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign sts.need_scan = need_scan;
    assign sts.scan_last = (cnt_reg == LAST_IDX);
    assign sts.out_free  = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_pre || cmd.load_fin) |=> result_valid_reg)
        else $error("loaded word not presented");

    a_reorder_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!result_reg.to_reorder || result_reg.verdict == V_FORWARD))
        else $error("to_reorder set on a dropped frame");

    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_IDX)
        else $error("ring pointer out of range");

endmodule

### sv/hfaf_ctrl.sv
module hfaf_ctrl
    import hfaf_pkg::*;
    (
    input  logic clk,
    input  logic rst_n,
    input  logic frame_valid,
    output logic frame_stall,
    input  sts_t sts,
    output cmd_t cmd
    );

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (sts.out_free)
                begin
                    cmd.load_pre = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_fin = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign frame_stall = (state_reg != S_IDLE);

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_pre || cmd.load_fin) |-> sts.out_free)
        else $error("word loaded over an untaken result");

endmodule

### sv/helper_frame_admission_filter_core.sv
// channel   dir  handshake                   word
// frame     in   frame_valid / frame_stall   in_word_t
// result    out  result_valid / result_stall out_word_t
// config    in   APB psel/penable/pwrite     64-bit registers at 8*index
//
// A word with an early verdict (clear, inactive, foreign, error, no station, QoS) is decided without a ring scan.
// A non-QoS word that passes those checks walks the sequence ring, one entry per cycle.
// Reset: ring empty (all entries read as zero), registers zero, no result pending.
// A new frame word is taken while a result waits; a stalled result holds the next one.
module helper_frame_admission_filter_core
    import hfaf_pkg::*;
    #(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
    )
    (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    output logic               frame_stall,
    input  in_word_t           frame,
    output logic               result_valid,
    input  logic               result_stall,
    output out_word_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
    );

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    hfaf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hfaf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    hfaf_dpath #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame        (frame),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
